### rtl/ssb_pkg.sv
// ----------------------------------------------------------------------------
// ssb_pkg: shared types and constants of the sensor superframe builder
// Request and result payloads, command codes, queue entry type and the
// lowest-set-slot helper used by the frame sequencer.
// ----------------------------------------------------------------------------
package ssb_pkg;

	// Usable sensor slots (0..3) and the fixed capacity of the presence field
	localparam int NUM_SLOTS      = 4;
	localparam int MAX_SLOTS      = 5;
	localparam int VALS_PER_SLOT  = 7;
	localparam int VAL_W          = 16;
	localparam int ROW_W          = VALS_PER_SLOT * VAL_W;
	localparam int BYTES_PER_SLOT = 2 * VALS_PER_SLOT;
	localparam int SLOT_W         = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int IDX_W          = 3;
	localparam int CNT_W          = 10;
	localparam int BCNT_W         = $clog2(BYTES_PER_SLOT);
	localparam int QUEUE_DEPTH    = 2;
	localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		CMD_STAGE = 1'b0,
		CMD_FLUSH = 1'b1
	} cmd_t;

	// One request as seen on the input port
	typedef struct packed {
		cmd_t              cmd;
		logic [IDX_W-1:0]  sensor_index;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
	} req_t;

	// One byte of the superframe
	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} frame_t;

	// Classified operation passed from front to back; value k sits at [16k +: 16]
	typedef struct packed {
		cmd_t              kind;
		logic [SLOT_W-1:0] slot;
		logic [ROW_W-1:0]  values;
	} op_t;

	// Index of the lowest set bit of a presence field (zero when empty)
	function automatic logic [IDX_W-1:0] first_slot(input logic [MAX_SLOTS-1:0] mask);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
			if (mask[i]) begin
				idx = IDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

### rtl/sensor_superframe_builder.sv
// ----------------------------------------------------------------------------
// sensor_superframe_builder: collects sensor samples and streams superframes
// Top level joining the request queue and the frame sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low. A stage
//   request writes seven values into a slot and marks it present; a flush
//   request sends the superframe as bytes on result, one per cycle with valid
//   high, last_byte marking the final one. Flushes with nothing present and
//   stages to missing slots produce nothing.
//   Requests wait in a two-entry queue; busy is high only when it is full.
//   Stage requests drain at one per cycle while the sequencer is idle, so
//   back-to-back stages stall only while a flush is being sent. A flush holds
//   the sequencer through its pop, two header bytes and then fourteen bytes
//   per present slot, read from the slot memory one row ahead. An accepted
//   flush passes the queue and the sequencer before its first byte is registered.
//   The receiver cannot hold results off; each byte is shown for one cycle.
//   Reset clears the queue, presence and frame counter; slot contents stay
//   undefined until written and are never sent before being written.
// ----------------------------------------------------------------------------
module sensor_superframe_builder (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  ssb_pkg::req_t   req,
	output logic            valid,
	output ssb_pkg::frame_t result
);
	import ssb_pkg::*;

	logic op_valid;
	op_t  op;
	logic pop;

	// Request intake and queue
	ssb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.op_valid (op_valid),
		.op       (op),
		.pop      (pop)
	);

	// Slot store and frame sequencer
	ssb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op       (op),
		.pop      (pop),
		.valid    (valid),
		.result   (result)
	);

endmodule

### rtl/ssb_front.sv
// ----------------------------------------------------------------------------
// ssb_front: request intake and operation queue
// Accepts requests, drops stages to slots that do not exist and queues the
// rest for the frame sequencer. Busy while the queue is full.
// ----------------------------------------------------------------------------
module ssb_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ssb_pkg::req_t req,
	output logic          op_valid,
	output ssb_pkg::op_t  op,
	input  logic          pop
);
	import ssb_pkg::*;

	op_t               entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              accept;
	logic              push;
	op_t               new_op;

	assign busy     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign accept   = start && !busy;
	assign op_valid = (count_q != '0);
	assign op       = entry_q[rd_ptr_q];

	// Classify: drop a stage whose slot is out of range
	always_comb begin
		push = accept && ((req.cmd == CMD_FLUSH) ||
			(req.sensor_index < IDX_W'(NUM_SLOTS)));
		new_op.kind   = req.cmd;
		new_op.slot   = req.sensor_index[SLOT_W-1:0];
		new_op.values = {req.quat_w, req.quat_z, req.quat_y, req.quat_x,
			req.accel_z, req.accel_y, req.accel_x};
	end

	// Store the queued payload
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_op;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

endmodule

### rtl/ssb_back.sv
// ----------------------------------------------------------------------------
// ssb_back: slot store and superframe sequencer
// Writes staged samples into the slot memory one row at a time and streams
// a superframe one byte per cycle on flush, then clears presence and bumps
// the frame counter.
// ----------------------------------------------------------------------------
module ssb_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            op_valid,
	input  ssb_pkg::op_t    op,
	output logic            pop,
	output logic            valid,
	output ssb_pkg::frame_t result
);
	import ssb_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_HDR0 = 4'b0010,
		ST_HDR1 = 4'b0100,
		ST_DATA = 4'b1000
	} back_state_t;

	logic [ROW_W-1:0]     slot_mem [NUM_SLOTS];
	logic [ROW_W-1:0]     row_q;
	back_state_t          state_q;
	logic [MAX_SLOTS-1:0] pres_q;
	logic [MAX_SLOTS-1:0] rem_q;
	logic [IDX_W-1:0]     cur_q;
	logic [BCNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]     ctr_q;
	logic                 valid_q;
	frame_t               result_q;

	logic                 mem_we;
	logic                 mem_re;
	logic                 start_flush;
	logic                 slot_end;
	logic [MAX_SLOTS-1:0] rem_next;
	logic [IDX_W-1:0]     first_idx;
	logic [IDX_W-1:0]     next_idx;
	logic [IDX_W-1:0]     rd_idx;
	logic                 emit;
	frame_t               emit_data;

	assign valid  = valid_q;
	assign result = result_q;

	// Pop only while idle; decide what the popped request does
	always_comb begin
		pop         = (state_q == ST_IDLE) && op_valid;
		mem_we      = pop && (op.kind == CMD_STAGE);
		start_flush = pop && (op.kind == CMD_FLUSH) && (pres_q != '0);
		first_idx   = first_slot(pres_q);
		rem_next    = rem_q & ~(MAX_SLOTS'(1) << cur_q);
		next_idx    = first_slot(rem_next);
		slot_end    = (state_q == ST_DATA) && (cnt_q == BCNT_W'(BYTES_PER_SLOT - 1));
		mem_re      = start_flush || (slot_end && (rem_next != '0));
		rd_idx      = start_flush ? first_idx : next_idx;
	end

	// Slot memory: one row write or one registered row read a cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[op.slot] <= op.values;
		end
		if (mem_re) begin
			row_q <= slot_mem[rd_idx[SLOT_W-1:0]];
		end
	end

	// Select the byte to send this cycle
	always_comb begin
		emit      = 1'b0;
		emit_data = '0;
		unique case (state_q)
			ST_HDR0: begin
				emit                 = 1'b1;
				emit_data.frame_byte = {pres_q, 1'b0, ctr_q[CNT_W-1:8]};
			end
			ST_HDR1: begin
				emit                 = 1'b1;
				emit_data.frame_byte = ctr_q[7:0];
			end
			ST_DATA: begin
				emit                 = 1'b1;
				emit_data.frame_byte = row_q[{cnt_q, 3'b000} +: 8];
				emit_data.last_byte  = slot_end && (rem_next == '0);
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Register the result byte
	always_ff @(posedge clk) begin
		result_q <= emit_data;
	end

	// Sequencer and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pres_q  <= '0;
			rem_q   <= '0;
			cur_q   <= '0;
			cnt_q   <= '0;
			ctr_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= emit;
			unique case (state_q)
				ST_IDLE: begin
					if (mem_we) begin
						pres_q <= pres_q | (MAX_SLOTS'(1) << op.slot);
					end
					if (start_flush) begin
						rem_q   <= pres_q;
						cur_q   <= first_idx;
						state_q <= ST_HDR0;
					end
				end
				ST_HDR0: begin
					state_q <= ST_HDR1;
				end
				ST_HDR1: begin
					cnt_q   <= '0;
					state_q <= ST_DATA;
				end
				ST_DATA: begin
					if (slot_end) begin
						cnt_q <= '0;
						if (rem_next == '0) begin
							pres_q  <= '0;
							ctr_q   <= ctr_q + 1'b1;
							state_q <= ST_IDLE;
						end else begin
							rem_q <= rem_next;
							cur_q <= next_idx;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
